// File: design/rls_pkg.sv
// Shared types and constants for the reversible LIFO stack.
`timescale 1ns / 1ps
package rls_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_DISPLAY = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [DepthW-1:0]        depth_t;

endpackage

// File: design/rls_if.sv
// Valid/ready channel interfaces for stack commands and stack results.
`timescale 1ns / 1ps
interface rls_cmd_if;
  logic              valid;
  logic              ready;
  rls_pkg::mode_e    mode;
  rls_pkg::value_t   push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface rls_rsp_if;
  logic              valid;
  logic              ready;
  rls_pkg::value_t   out_value;
  rls_pkg::status_e  status;
  rls_pkg::depth_t   depth_now;
  logic              last;

  modport source (output valid, output out_value, output status, output depth_now,
                  output last, input ready);
  modport sink   (input valid, input out_value, input status, input depth_now,
                  input last, output ready);
endinterface

// File: design/rls_ram.sv
// Generic simple dual-port RAM with registered read that holds without a read.
`timescale 1ns / 1ps
module rls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/reversible_lifo_stack_core.sv
// Reversible LIFO stack: pointer control, element RAM, display walker, result register.
// Push, reverse and failed operations: result valid in the cycle after the command transaction.
// Pop: RAM read of the top slot, then a move into the result register; the next command waits for that move.
// Display of N elements: walk state, RAM read, then result register for each element; one result
// per cycle while out ready holds, paced by the single RAM read port; next command accepted once the walk has drained.
// Asynchronous active-low reset empties the stack; the element RAM is not cleared.
`timescale 1ns / 1ps
module reversible_lifo_stack_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rls_cmd_if.sink   in_i,
  rls_rsp_if.source out_o
);
  import rls_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(STACK_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(STACK_DEPTH);

  state_e        state_q, state_d;
  logic [AW-1:0] top_q, top_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          flip_q, flip_d;
  logic [AW-1:0] walk_addr_q, walk_addr_d;
  logic [CW-1:0] walk_k_q, walk_k_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;

  logic          out_valid_q, out_valid_d;
  value_t        out_value_q, out_value_d;
  status_e       out_status_q, out_status_d;
  logic          out_last_q, out_last_d;
  logic          out_load;

  logic          accept, out_free, move, issue;
  logic          empty, full;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic [AW-1:0] top_inc, top_dec, walk_inc, walk_dec;
  logic [AW-1:0] cnt_m1;
  logic [AW:0]   rev_sum;
  logic [AW-1:0] rev_top;
  logic [CW+DepthW-1:0] cnt_ext;

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q >= FullCnt);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && !pend_q && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign move     = pend_q && out_free;
  assign issue    = (state_q == ST_WALK) && (!pend_q || move);

  // Circular slot neighbors of the top and of the walk pointer
  assign top_inc  = (top_q == LastSlot) ? '0 : top_q + 1'b1;
  assign top_dec  = (top_q == '0) ? LastSlot : top_q - 1'b1;
  assign walk_inc = (walk_addr_q == LastSlot) ? '0 : walk_addr_q + 1'b1;
  assign walk_dec = (walk_addr_q == '0) ? LastSlot : walk_addr_q - 1'b1;

  // Slot of the bottom element, the new top after a reverse
  assign cnt_m1 = AW'(cnt_q - 1'b1);
  always_comb begin
    rev_sum = '0;
    rev_top = top_q;
    if (flip_q) begin
      rev_sum = {1'b0, top_q} + {1'b0, cnt_m1};
      rev_top = (rev_sum >= (AW+1)'(STACK_DEPTH)) ?
                AW'(rev_sum - (AW+1)'(STACK_DEPTH)) : AW'(rev_sum);
    end else begin
      rev_top = (top_q >= cnt_m1) ? top_q - cnt_m1 :
                AW'((AW+1)'(top_q) + (AW+1)'(STACK_DEPTH) - (AW+1)'(cnt_m1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.mode == MODE_DISPLAY && !empty) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue && (walk_k_q == cnt_q - 1'b1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command execution, RAM access and result staging
  always_comb begin
    top_d        = top_q;
    cnt_d        = cnt_q;
    flip_d       = flip_q;
    walk_addr_d  = walk_addr_q;
    walk_k_d     = walk_k_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    ram_we       = 1'b0;
    ram_waddr    = top_q;
    ram_re       = 1'b0;
    ram_raddr    = top_q;
    out_load     = 1'b0;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (accept) begin
      out_value_d = '0;
      out_last_d  = 1'b1;
      case (in_i.mode)
        MODE_PUSH: begin
          out_load = 1'b1;
          if (full) begin
            out_status_d = STATUS_OVERFLOW;
          end else begin
            out_status_d = STATUS_OK;
            if (!empty) begin
              top_d = flip_q ? top_dec : top_inc;
            end
            ram_we    = 1'b1;
            ram_waddr = top_d;
            cnt_d     = cnt_q + 1'b1;
          end
        end
        MODE_POP: begin
          if (empty) begin
            out_load     = 1'b1;
            out_status_d = STATUS_UNDERFLOW;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = top_q;
            pend_d      = 1'b1;
            pend_last_d = 1'b1;
            cnt_d       = cnt_q - 1'b1;
            if (cnt_q != CW'(1)) begin
              top_d = flip_q ? top_inc : top_dec;
            end
          end
        end
        MODE_DISPLAY: begin
          if (empty) begin
            out_load     = 1'b1;
            out_status_d = STATUS_EMPTY;
          end else begin
            walk_addr_d = top_q;
            walk_k_d    = '0;
          end
        end
        default: begin
          out_load     = 1'b1;
          out_status_d = STATUS_OK;
          if (cnt_q > CW'(1)) begin
            top_d  = rev_top;
            flip_d = !flip_q;
          end
        end
      endcase
    end

    // Move a finished RAM read into the result register
    if (move) begin
      out_load     = 1'b1;
      out_value_d  = value_t'(ram_rdata);
      out_status_d = STATUS_OK;
      out_last_d   = pend_last_q;
      pend_d       = 1'b0;
    end

    // Advance the display walk by one element
    if (issue) begin
      ram_re      = 1'b1;
      ram_raddr   = walk_addr_q;
      pend_d      = 1'b1;
      pend_last_d = (walk_k_q == cnt_q - 1'b1);
      walk_addr_d = flip_q ? walk_inc : walk_dec;
      walk_k_d    = walk_k_q + 1'b1;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      cnt_q       <= '0;
      flip_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      walk_k_q    <= '0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      flip_q      <= flip_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      walk_k_q    <= walk_k_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_addr_q  <= walk_addr_d;
    pend_last_q  <= pend_last_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  rls_ram #(
    .Width (ValueW),
    .Depth (STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Count after the operation, truncated to the result field
  assign cnt_ext = {{DepthW{1'b0}}, cnt_q};

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.depth_now = cnt_ext[DepthW-1:0];
  assign out_o.last      = out_last_q;

endmodule

// File: tb/reversible_lifo_stack_core_tb.sv
// Self-checking testbench for the reversible LIFO stack core: predictor and random traffic.
`timescale 1ns / 1ps
module reversible_lifo_stack_core_tb;
  import rls_pkg::*;

  localparam int StackDepth = 64;
  localparam int ItemTarget = 400;
  localparam int MaxReports = 25;

  typedef struct {
    value_t  value;
    status_e status;
    depth_t  depth;
    logic    last;
  } stack_result_t;

  // Mirror of the stack contents plus the queue of results still owed by the core
  class stack_scoreboard;
    value_t        stack_words [StackDepth];
    int            top_slot;
    int            word_count;
    bit            flipped;
    stack_result_t owed_results [$];
    int            mismatches;
    int            results_checked;
    int            overflows;
    int            underflows;
    int            peak_depth;
    int            mode_hits [4];

    function new();
      top_slot   = 0;
      word_count = 0;
      flipped    = 1'b0;
      mismatches = 0;
      results_checked = 0;
      overflows  = 0;
      underflows = 0;
      peak_depth = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    // Slot of the element k positions below the top
    function int slot_below(int k);
      return flipped ? (top_slot + k) % StackDepth : (top_slot + StackDepth - k) % StackDepth;
    endfunction

    function void owe(value_t v, status_e s, logic l);
      stack_result_t r;
      r.value  = v;
      r.status = s;
      r.depth  = depth_t'(word_count);
      r.last   = l;
      owed_results.push_back(r);
    endfunction

    // Apply one accepted command and queue the results it must produce
    function void note_command(mode_e op, value_t v);
      value_t popped;
      mode_hits[int'(op)]++;
      case (op)
        MODE_PUSH: begin
          if (word_count >= StackDepth) begin
            overflows++;
            owe('0, STATUS_OVERFLOW, 1'b1);
          end else begin
            if (word_count > 0)
              top_slot = flipped ? (top_slot + StackDepth - 1) % StackDepth
                                 : (top_slot + 1) % StackDepth;
            stack_words[top_slot] = v;
            word_count++;
            if (word_count > peak_depth) peak_depth = word_count;
            owe('0, STATUS_OK, 1'b1);
          end
        end
        MODE_POP: begin
          if (word_count == 0) begin
            underflows++;
            owe('0, STATUS_UNDERFLOW, 1'b1);
          end else begin
            popped = stack_words[top_slot];
            word_count--;
            if (word_count > 0) top_slot = slot_below(1);
            owe(popped, STATUS_OK, 1'b1);
          end
        end
        MODE_DISPLAY: begin
          if (word_count == 0) begin
            owe('0, STATUS_EMPTY, 1'b1);
          end else begin
            for (int k = 0; k < word_count; k++)
              owe(stack_words[slot_below(k)], STATUS_OK, k + 1 == word_count);
          end
        end
        default: begin
          // Reverse: the old bottom becomes the top and the growth direction flips
          if (word_count > 1) begin
            top_slot = slot_below(word_count - 1);
            flipped  = !flipped;
          end
          owe('0, STATUS_OK, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("reversible_lifo_stack_core_tb: MISMATCH %s", msg);
    endtask

    // Compare one result transaction against the oldest owed result
    task check_result(value_t v, status_e s, depth_t d, logic l);
      stack_result_t want;
      results_checked++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: value %0d status %0d depth %0d last %0b",
                                  v, s, d, l));
        return;
      end
      want = owed_results.pop_front();
      if (v !== want.value)
        report_mismatch($sformatf("result %0d: out_value %0d, want %0d",
                                  results_checked, v, want.value));
      if (s !== want.status)
        report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                  results_checked, s, want.status));
      if (d !== want.depth)
        report_mismatch($sformatf("result %0d: depth_now %0d, want %0d",
                                  results_checked, d, want.depth));
      if (l !== want.last)
        report_mismatch($sformatf("result %0d: last %0b, want %0b",
                                  results_checked, l, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  rls_cmd_if cmd_if ();
  rls_rsp_if rsp_if ();

  reversible_lifo_stack_core #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if.sink),
    .out_o (rsp_if.source)
  );

  stack_scoreboard sb;
  int items_sent = 0;
  int tx_quiet   = 0;
  int rx_quiet   = 0;
  int rx_stall   = 0;
  int rx_gap;

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int idle_length(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Bias toward the extremes, otherwise any 32-bit pattern
  function automatic value_t random_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Drive one command transaction, optionally after an idle gap
  task automatic send_command(mode_e op, value_t v);
    int gap;
    @(negedge clk_i);
    gap = idle_length(tx_quiet);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.mode       <= op;
    cmd_if.push_value <= v;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    sb.note_command(op, v);
    items_sent++;
  endtask

  task automatic fill_stack();
    while (sb.word_count < StackDepth) send_command(MODE_PUSH, random_value());
  endtask

  // Result side: hold ready low for random stalls
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rx_stall--;
    end else begin
      rx_gap = idle_length(rx_quiet);
      if (rx_gap > 0) begin
        rsp_if.ready <= 1'b0;
        rx_stall = rx_gap - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_result(rsp_if.out_value, rsp_if.status, rsp_if.depth_now, rsp_if.last);
  end

  initial begin
    #(64'd100_000_000);
    $display("reversible_lifo_stack_core_tb: done, errors");
    $finish;
  end

  initial begin
    int r;
    int pick;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.mode       = MODE_PUSH;
    cmd_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    sb = new();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-stack cases, single-element reverse, extremes, reorder and drain
    send_command(MODE_POP, '0);
    send_command(MODE_DISPLAY, '0);
    send_command(MODE_REVERSE, '0);
    send_command(MODE_PUSH, 32'sh7fff_ffff);
    send_command(MODE_REVERSE, -1);
    send_command(MODE_DISPLAY, -1);
    send_command(MODE_PUSH, 32'sh8000_0000);
    send_command(MODE_PUSH, '0);
    send_command(MODE_PUSH, -1);
    send_command(MODE_PUSH, 32'sh5a5a_a5a5);
    send_command(MODE_DISPLAY, '0);
    send_command(MODE_REVERSE, '0);
    send_command(MODE_DISPLAY, '0);
    send_command(MODE_POP, '0);
    send_command(MODE_PUSH, 32'sh0000_0001);
    send_command(MODE_REVERSE, '0);
    send_command(MODE_DISPLAY, '0);
    for (int i = 0; i < 5; i++) send_command(MODE_POP, '0);
    send_command(MODE_DISPLAY, '0);

    // Full stack: walk it, reverse it, overflow it, pop at full
    fill_stack();
    send_command(MODE_DISPLAY, random_value());
    send_command(MODE_REVERSE, random_value());
    send_command(MODE_DISPLAY, random_value());
    send_command(MODE_PUSH, random_value());
    send_command(MODE_POP, random_value());

    // Random: mostly mixed traffic, with fill, drain and reorder bursts
    while (items_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        fill_stack();
        repeat ($urandom_range(1, 3)) send_command(MODE_PUSH, random_value());
      end else if (r < 6) begin
        while (sb.word_count > 0) send_command(MODE_POP, random_value());
        send_command(MODE_POP, random_value());
      end else if (r < 10) begin
        send_command(MODE_DISPLAY, random_value());
        send_command(MODE_REVERSE, random_value());
        send_command(MODE_DISPLAY, random_value());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      send_command(MODE_PUSH, random_value());
        else if (pick < 70) send_command(MODE_POP, random_value());
        else if (pick < 80) send_command(MODE_DISPLAY, random_value());
        else                send_command(MODE_REVERSE, random_value());
      end
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    // Drain owed results, then watch for strays
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("reversible_lifo_stack_core_tb: %0d commands (push %0d, pop %0d, display %0d,",
             items_sent, sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2]);
    $display("  reverse %0d), %0d results checked, peak depth %0d",
             sb.mode_hits[3], sb.results_checked, sb.peak_depth);
    $display("  %0d overflows, %0d underflows, %0d mismatches",
             sb.overflows, sb.underflows, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("reversible_lifo_stack_core_tb: done, clean");
    end else begin
      $display("reversible_lifo_stack_core_tb: done, errors");
    end
    $finish;
  end

endmodule
